// ===== rtl/positional_array_list_defines.svh =====
// Assertion helpers shared by the block's RTL.
// All expect clk and rst_n in scope; checks are off while reset is held.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// expr must hold at every clock edge
`define PAL_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// when ante holds, cons must hold on the following edge
`define PAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// when ante holds, cons must hold on the same edge
`define PAL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

    localparam int CAPACITY = 16;

    // field widths of the transfers
    localparam int REQ_W   = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // internal widths derived from the capacity
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]        req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } pal_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic [COUNT_W-1:0]      count;
    } pal_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEARCH,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR
    } pal_state_t;

endpackage

// ===== rtl/pal_ram.sv =====
`timescale 1ns / 1ps

// one write port, one registered read port
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/positional_array_list.sv =====
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+---------------------------------------
// req     | in  | req_valid, req_ready | pal_req_t: req_type, position, value
// rsp     | out | rsp_valid, rsp_ready | pal_rsp_t: status, found, read_value,
//         |     |                      |            count
//
// Append, clear, no-op and every error finish in the accepting state; read, search,
// insert and delete go on through further states, the last three once per entry scanned or shifted.
// The registered RAM read shapes these: a shifted entry is a read state then a write state.
// req_ready is high only when idle with the response slot free or draining, so a
// response held by rsp_ready low stalls the next request.
// Reset (rst_n, async low) clears count and control; entries are never read past the count.
`timescale 1ns / 1ps
`include "positional_array_list_defines.svh"

module positional_array_list
    import pal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pal_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pal_rsp_t rsp
);

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    pal_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;      // shift / scan index
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic                    pend_reg, pend_next;    // a search read is in flight
    logic                    found_reg, found_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    pal_rsp_t                rsp_reg, rsp_next;

    // entry RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W-1:0]  rd_data;

    pal_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic req_fire;
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;

    // Position arithmetic is done in a width that holds both the count
    // and the position field plus one, so count + 1 never wraps.
    logic [WIDE_W-1:0] in_pos_w, in_pos_m1, cnt_w, idx_w, pos_w;
    assign in_pos_w  = WIDE_W'(req.position);
    assign in_pos_m1 = in_pos_w - WIDE_W'(1);
    assign cnt_w     = WIDE_W'(cnt_reg);
    assign idx_w     = WIDE_W'(idx_reg);
    assign pos_w     = WIDE_W'(pos_reg);

    // single comparator shared by all search steps
    logic hit;
    assign hit = pend_reg && (rd_data == val_reg);

    // response build
    logic              fin;
    logic [STAT_W-1:0] fin_status;
    logic              fin_found;
    logic [VAL_W-1:0]  fin_rd;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[ADDR_W-1:0];
        wr_data    = rd_data;
        rd_addr    = idx_reg[ADDR_W-1:0];
        fin        = 1'b0;
        fin_status = STAT_OK;
        fin_found  = 1'b0;
        fin_rd     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    pos_next = req.position;
                    val_next = req.value;
                    unique case (req.req_type)
                        REQ_READ:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                            else if (in_pos_w == '0 || in_pos_w > cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BADPOS;
                            end
                            else
                            begin
                                rd_addr    = in_pos_m1[ADDR_W-1:0];
                                state_next = ST_READ;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                pend_next  = 1'b0;
                                found_next = 1'b0;
                                state_next = ST_SEARCH;
                            end
                        end
                        REQ_APPEND:
                        begin
                            fin = 1'b1;
                            if (cnt_w == WIDE_W'(CAPACITY))
                            begin
                                fin_status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = cnt_reg[ADDR_W-1:0];
                                wr_data  = req.value;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (cnt_w == WIDE_W'(CAPACITY))
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_FULL;
                            end
                            else if (in_pos_w == '0 || in_pos_w > cnt_w + WIDE_W'(1))
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BADPOS;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                            else if (in_pos_w == '0 || in_pos_w > cnt_w)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_BADPOS;
                            end
                            else
                            begin
                                idx_next   = in_pos_m1[CNT_W-1:0];
                                state_next = ST_DEL_RD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fin = 1'b1;
                            if (cnt_reg == '0)
                            begin
                                fin_status = STAT_EMPTY;
                            end
                            else
                            begin
                                cnt_next = '0;
                            end
                        end
                        default:
                        begin
                            // unused codes: no-op with ok status
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                fin        = 1'b1;
                fin_rd     = rd_data;
                state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                // read index idx while the previous read is compared
                found_next = found_reg || hit;
                if (idx_reg < cnt_reg)
                begin
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        fin        = 1'b1;
                        fin_found  = found_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_INS_RD:
            begin
                if (idx_w >= pos_w)
                begin
                    rd_addr    = idx_w[ADDR_W-1:0] - ADDR_W'(1);
                    state_next = ST_INS_WR;
                end
                else
                begin
                    // gap is open: drop the new value in
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[ADDR_W-1:0];
                    wr_data    = val_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_INS_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - CNT_W'(1);
                state_next = ST_INS_RD;
            end
            ST_DEL_RD:
            begin
                if (idx_w + WIDE_W'(1) < cnt_w)
                begin
                    rd_addr    = idx_w[ADDR_W-1:0] + ADDR_W'(1);
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    fin        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DEL_WR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_reg + CNT_W'(1);
                state_next = ST_DEL_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // response slot: drains on transfer, loads when a request finishes
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (fin)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.status     = fin_status;
            rsp_next.found      = fin_found;
            rsp_next.read_value = fin_rd;
            rsp_next.count      = COUNT_W'(cnt_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `PAL_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PAL_ASSERT_SAME(a_busy_slot_free, state_reg != ST_IDLE, !rsp_valid_reg,
        "response slot occupied during a multi-cycle request")
    `PAL_ASSERT_NEXT(a_clear_empties, req_fire && req.req_type == REQ_CLEAR,
        cnt_reg == '0 && rsp_valid_reg && rsp_reg.count == '0, "clear left entries")
    `PAL_ASSERT_SAME(a_search_idx, state_reg == ST_SEARCH, idx_reg <= cnt_reg,
        "search index ran past the count")

endmodule
